FILE: rtl/cma_pkg.sv
package cma_pkg;

  // Accumulator store geometry
  localparam int ACC_W   = 64;
  localparam int DEPTH   = 64;
  localparam int ADDR_W  = 6;
  localparam int RAM_W   = 2 * ACC_W;

  // Register indexes on the configuration port
  localparam logic REG_BETA       = 1'b0;
  localparam logic REG_NUM_COEFFS = 1'b1;

  localparam logic [31:0] BETA_RESET   = 32'd65536;
  localparam logic [5:0]  NC_RESET     = 6'd31;
  localparam logic [5:0]  MAX_ORDER    = 6'd63;

  // Fixed point constants
  localparam logic signed [31:0] ONE_Q30      = 32'sd1073741824;
  localparam logic [61:0]        ONE_Q60      = 62'd1 << 60;
  localparam logic [31:0]        WEIGHT_CLIP  = 32'hFFFF_FFFF;
  // Above this root the factor 2^54/s fits in 32 bits
  localparam logic [30:0]        ROOT_LIMIT   = 31'd4194304;
  // 2^54 taken apart: top part as the first remainder, 32 zero bits to follow
  localparam logic [31:0]        F_REM0       = 32'd4194304;
  localparam logic [31:0]        INV_PI_Q32   = 32'd1367130551;
  localparam logic [31:0]        TWO_INV_PI_Q32 = 32'd2734261102;

  localparam logic [5:0] X_DIV_STEPS = 6'd31;
  localparam logic [5:0] F_DIV_STEPS = 6'd32;

  typedef struct packed {
    logic        start;
    logic [31:0] rem0;
    logic [31:0] low;
    logic [31:0] divisor;
    logic [5:0]  steps;
  } div_req_t;

  typedef struct packed {
    logic        done;
    logic [31:0] quot;
  } div_rsp_t;

  typedef struct packed {
    logic        start;
    logic [61:0] radicand;
  } sqrt_req_t;

  typedef struct packed {
    logic        done;
    logic [30:0] root;
  } sqrt_rsp_t;

endpackage

FILE: rtl/chebyshev_moment_accumulator_top.sv
// Chebyshev moment accumulator.
// Input channel (in_valid/in_ready): one word per sample carrying sample_time,
// weight_re, weight_im and last_sample. Output channel (out_valid/out_ready):
// one word per coefficient, coeff_index 0..n, last_coeff on order n.
// Configuration: cfg_we writes cfg_data into register cfg_index (0 beta,
// 1 num_coeffs); user rule, not enforced: only while no sample is in flight.
// A sample is handled alone: in_ready is high only while the block is idle.
// Per sample the steps run in order: the time divide, the square root, the
// weight-factor divide (skipped when the factor clips; the shared divider
// serves both), the accumulate loop over orders 0..n through the accumulator
// RAM read-modify-write and its drain; no new word is accepted before the
// drain ends. On a last sample the coefficients then follow in order, and
// the next word waits for the last one; a stalled word holds in the output
// register until out_ready.
// Reset loads beta=1.0 and num_coeffs=31 and clears the per-order valid
// flags at once, so every accumulator reads as zero; no clearing pass.
module chebyshev_moment_accumulator_top
  import cma_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic [31:0]        cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic [31:0]        sample_time,
  input  logic signed [31:0] weight_re,
  input  logic signed [31:0] weight_im,
  input  logic               last_sample,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [5:0]         coeff_index,
  output logic signed [63:0] coeff_re,
  output logic signed [63:0] coeff_im,
  output logic               last_coeff
);

  localparam logic [3:0] S_IDLE  = 4'd0;
  localparam logic [3:0] S_XDIV  = 4'd1;
  localparam logic [3:0] S_XWAIT = 4'd2;
  localparam logic [3:0] S_SQ    = 4'd3;
  localparam logic [3:0] S_RGO   = 4'd4;
  localparam logic [3:0] S_RWAIT = 4'd5;
  localparam logic [3:0] S_FDIV  = 4'd6;
  localparam logic [3:0] S_FWAIT = 4'd7;
  localparam logic [3:0] S_SCALE = 4'd8;
  localparam logic [3:0] S_ACC   = 4'd9;
  localparam logic [3:0] S_DRAIN = 4'd10;
  localparam logic [3:0] S_ORD   = 4'd11;
  localparam logic [3:0] S_OMUL  = 4'd12;
  localparam logic [3:0] S_OSUM  = 4'd13;
  localparam logic [3:0] S_OHOLD = 4'd14;

  logic [3:0]  state;
  logic [31:0] beta_r;
  logic [5:0]  nc_r;

  logic [31:0]        b_q;
  logic [31:0]        a_q;
  logic               neg_q;
  logic               last_q;
  logic [5:0]         n_q;
  logic signed [31:0] wre_q;
  logic signed [31:0] wim_q;
  logic signed [31:0] x_q;
  logic [30:0]        xm_q;
  logic [61:0]        d_q;
  logic [30:0]        s_q;
  logic [31:0]        f_q;
  logic signed [32:0] sre_q;
  logic signed [32:0] sim_q;
  logic [5:0]         k_q;
  logic signed [31:0] tm1;
  logic signed [31:0] tm2;

  logic               va;
  logic [5:0]         ka;
  logic signed [31:0] tka;
  logic               vb;
  logic [5:0]         kb;
  logic signed [63:0] pre_b;
  logic signed [63:0] pim_b;

  logic [DEPTH-1:0]  vld;
  logic              rvld;
  logic [ADDR_W-1:0] raddr;
  logic [RAM_W-1:0]  rdata;
  logic [RAM_W-1:0]  wdata;

  logic signed [63:0] ph_re;
  logic signed [63:0] ph_im;
  logic [63:0]        pl_re;
  logic [63:0]        pl_im;

  div_req_t  dreq;
  div_rsp_t  drsp;
  sqrt_req_t sreq;
  sqrt_rsp_t srsp;

  // Input mapping of the time onto |2t-b|
  logic [31:0] b_eff;
  logic [31:0] t_c;
  logic [32:0] t2;
  logic        ge_c;
  logic [32:0] a_c;

  always_comb begin
    b_eff = (beta_r == 32'd0) ? 32'd1 : beta_r;
    t_c   = (sample_time > b_eff) ? b_eff : sample_time;
    t2    = {t_c, 1'b0};
    ge_c  = t2 >= {1'b0, b_eff};
    a_c   = ge_c ? (t2 - {1'b0, b_eff}) : ({1'b0, b_eff} - t2);
  end

  // Divider requests: time quotient, then weight factor
  logic [62:0] num_x;

  always_comb begin
    num_x = {1'b0, a_q, 30'd0} + {32'd0, b_q[31:1]};
    dreq  = '0;
    if (state == S_XDIV) begin
      dreq.start   = 1'b1;
      dreq.rem0    = num_x[62:31];
      dreq.low     = {num_x[30:0], 1'b0};
      dreq.divisor = b_q;
      dreq.steps   = X_DIV_STEPS;
    end else if (state == S_FDIV && s_q > ROOT_LIMIT) begin
      dreq.start   = 1'b1;
      dreq.rem0    = F_REM0;
      dreq.low     = '0;
      dreq.divisor = {1'b0, s_q};
      dreq.steps   = F_DIV_STEPS;
    end
    sreq.start    = (state == S_RGO);
    sreq.radicand = d_q;
  end

  cma_div u_div (
    .clk (clk),
    .rst (rst),
    .req (dreq),
    .rsp (drsp)
  );

  cma_sqrt u_sqrt (
    .clk (clk),
    .rst (rst),
    .req (sreq),
    .rsp (srsp)
  );

  // Chebyshev recurrence for the current order
  logic signed [63:0] rec_p;
  logic signed [35:0] rec_d;
  logic signed [31:0] tk;

  always_comb begin
    rec_p = x_q * tm1;
    rec_d = {rec_p[63], rec_p[63:29]} - {{4{tm2[31]}}, tm2};
    if (k_q == 6'd0) begin
      tk = ONE_Q30;
    end else if (k_q == 6'd1) begin
      tk = x_q;
    end else if (rec_d > 36'(ONE_Q30)) begin
      tk = ONE_Q30;
    end else if (rec_d < -36'(ONE_Q30)) begin
      tk = -ONE_Q30;
    end else begin
      tk = rec_d[31:0];
    end
  end

  // Saturating add of the term onto the stored accumulator
  logic signed [63:0] acc_re_rd;
  logic signed [63:0] acc_im_rd;
  logic signed [64:0] sum_re;
  logic signed [64:0] sum_im;
  logic signed [63:0] new_re;
  logic signed [63:0] new_im;

  always_comb begin
    acc_re_rd = rvld ? rdata[RAM_W-1:ACC_W] : 64'sd0;
    acc_im_rd = rvld ? rdata[ACC_W-1:0] : 64'sd0;
    sum_re = {acc_re_rd[63], acc_re_rd} + {pre_b[63], pre_b};
    sum_im = {acc_im_rd[63], acc_im_rd} + {pim_b[63], pim_b};
    if (sum_re[64] != sum_re[63]) begin
      new_re = sum_re[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      new_re = sum_re[63:0];
    end
    if (sum_im[64] != sum_im[63]) begin
      new_im = sum_im[64] ? {1'b1, 63'd0} : {1'b0, {63{1'b1}}};
    end else begin
      new_im = sum_im[63:0];
    end
    wdata = {new_re, new_im};
    raddr = va ? ka : k_q;
  end

  cma_ram #(
    .WIDTH (RAM_W),
    .DEPTH (DEPTH)
  ) u_ram (
    .clk   (clk),
    .we    (vb),
    .waddr (kb),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  // Output scaling partial products
  logic [31:0]        kc;
  logic signed [32:0] kc_s;
  logic signed [64:0] ph_re_c;
  logic signed [64:0] ph_im_c;

  always_comb begin
    kc      = (k_q == 6'd0) ? INV_PI_Q32 : TWO_INV_PI_Q32;
    kc_s    = {1'b0, kc};
    ph_re_c = $signed(acc_re_rd[63:32]) * kc_s;
    ph_im_c = $signed(acc_im_rd[63:32]) * kc_s;
  end

  // Products for the accumulate pipeline, the weight scaling and the root radicand
  logic signed [64:0] tp_re;
  logic signed [64:0] tp_im;
  logic signed [64:0] sw_re;
  logic signed [64:0] sw_im;
  logic [61:0]        xsq;

  always_comb begin
    tp_re = sre_q * tka;
    tp_im = sim_q * tka;
    sw_re = wre_q * $signed({1'b0, f_q});
    sw_im = wim_q * $signed({1'b0, f_q});
    xsq   = {31'd0, xm_q} * {31'd0, xm_q};
  end

  always_ff @(posedge clk) begin
    pre_b <= tp_re[63:0];
    pim_b <= tp_im[63:0];
    kb    <= ka;
    rvld  <= vld[raddr];
    ph_re <= ph_re_c[63:0];
    ph_im <= ph_im_c[63:0];
    pl_re <= {32'd0, acc_re_rd[31:0]} * {32'd0, kc};
    pl_im <= {32'd0, acc_im_rd[31:0]} * {32'd0, kc};
  end

  // Control sequencer and registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      beta_r    <= BETA_RESET;
      nc_r      <= NC_RESET;
      va        <= 1'b0;
      vb        <= 1'b0;
      vld       <= '0;
      out_valid <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (cfg_index == REG_BETA) begin
          beta_r <= cfg_data;
        end else begin
          nc_r <= cfg_data[5:0];
        end
      end
      va <= (state == S_ACC);
      vb <= va;
      if (vb) begin
        vld[kb] <= 1'b1;
      end
      case (state)
        S_IDLE: begin
          if (in_valid) begin
            state <= S_XDIV;
          end
        end
        S_XDIV: state <= S_XWAIT;
        S_XWAIT: begin
          if (drsp.done) begin
            state <= S_SQ;
          end
        end
        S_SQ: state <= S_RGO;
        S_RGO: state <= S_RWAIT;
        S_RWAIT: begin
          if (srsp.done) begin
            state <= S_FDIV;
          end
        end
        S_FDIV: begin
          state <= (s_q > ROOT_LIMIT) ? S_FWAIT : S_SCALE;
        end
        S_FWAIT: begin
          if (drsp.done) begin
            state <= S_SCALE;
          end
        end
        S_SCALE: state <= S_ACC;
        S_ACC: begin
          if (k_q == n_q) begin
            state <= S_DRAIN;
          end
        end
        S_DRAIN: begin
          if (!va && !vb) begin
            state <= last_q ? S_ORD : S_IDLE;
          end
        end
        S_ORD: state <= S_OMUL;
        S_OMUL: state <= S_OSUM;
        S_OSUM: begin
          out_valid <= 1'b1;
          state     <= S_OHOLD;
        end
        S_OHOLD: begin
          if (out_ready) begin
            out_valid <= 1'b0;
            if (k_q == n_q) begin
              vld   <= '0;
              state <= S_IDLE;
            end else begin
              state <= S_ORD;
            end
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  // Datapath registers per state
  always_ff @(posedge clk) begin
    case (state)
      S_IDLE: begin
        b_q    <= b_eff;
        a_q    <= a_c[31:0];
        neg_q  <= !ge_c;
        last_q <= last_sample;
        n_q    <= (nc_r == 6'd0) ? 6'd1 : ((nc_r > MAX_ORDER) ? MAX_ORDER : nc_r);
        wre_q  <= weight_re;
        wim_q  <= weight_im;
      end
      S_XWAIT: begin
        xm_q <= drsp.quot[30:0];
        x_q  <= neg_q ? -$signed({1'b0, drsp.quot[30:0]}) : $signed({1'b0, drsp.quot[30:0]});
      end
      S_SQ: d_q <= ONE_Q60 - xsq;
      S_RWAIT: s_q <= srsp.root;
      S_FDIV: f_q <= WEIGHT_CLIP;
      S_FWAIT: f_q <= drsp.quot;
      S_SCALE: begin
        sre_q <= sw_re[64:32];
        sim_q <= sw_im[64:32];
        k_q   <= 6'd0;
      end
      S_ACC: begin
        tka <= tk;
        ka  <= k_q;
        tm2 <= tm1;
        tm1 <= tk;
        if (k_q != n_q) begin
          k_q <= k_q + 6'd1;
        end
      end
      S_DRAIN: k_q <= 6'd0;
      S_OSUM: begin
        coeff_index <= k_q;
        coeff_re    <= ph_re + $signed({32'd0, pl_re[63:32]});
        coeff_im    <= ph_im + $signed({32'd0, pl_im[63:32]});
        last_coeff  <= (k_q == n_q);
      end
      S_OHOLD: begin
        if (out_ready && k_q != n_q) begin
          k_q <= k_q + 6'd1;
        end
      end
      default: begin
      end
    endcase
  end

  assign in_ready = (state == S_IDLE);

endmodule

FILE: rtl/cma_ram.sv
module cma_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

FILE: rtl/cma_div.sv
module cma_div
  import cma_pkg::*;
(
  input  logic     clk,
  input  logic     rst,
  input  div_req_t req,
  output div_rsp_t rsp
);

  logic        busy;
  logic [31:0] rem;
  logic [31:0] low;
  logic [31:0] dvs;
  logic [31:0] quot;
  logic [5:0]  cnt;
  logic        done;

  logic [32:0] trial;
  logic        ge;
  logic [32:0] diff;

  // One quotient bit per cycle
  always_comb begin
    trial = {rem, low[31]};
    ge    = trial >= {1'b0, dvs};
    diff  = trial - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && cnt == 6'd1;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 6'd1) begin
        busy <= 1'b0;
      end
    end
  end

  // Shift remainder, numerator bits and quotient
  always_ff @(posedge clk) begin
    if (req.start) begin
      rem  <= req.rem0;
      low  <= req.low;
      dvs  <= req.divisor;
      cnt  <= req.steps;
      quot <= '0;
    end else if (busy) begin
      rem  <= ge ? diff[31:0] : trial[31:0];
      low  <= {low[30:0], 1'b0};
      quot <= {quot[30:0], ge};
      cnt  <= cnt - 6'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.quot = quot;

endmodule

FILE: rtl/cma_sqrt.sv
module cma_sqrt
  import cma_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  sqrt_req_t req,
  output sqrt_rsp_t rsp
);

  logic        busy;
  logic        done;
  logic [61:0] dsh;
  logic [32:0] rem;
  logic [30:0] root;
  logic [4:0]  cnt;

  logic [34:0] rem_sh;
  logic [34:0] trial;
  logic        ge;
  logic [34:0] diff;

  // One root bit per cycle, two radicand bits brought down
  always_comb begin
    rem_sh = {rem, dsh[61:60]};
    trial  = {2'b00, root, 2'b01};
    ge     = rem_sh >= trial;
    diff   = rem_sh - trial;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
    end else begin
      done <= !req.start && busy && cnt == 5'd1;
      if (req.start) begin
        busy <= 1'b1;
      end else if (busy && cnt == 5'd1) begin
        busy <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req.start) begin
      dsh  <= req.radicand;
      rem  <= '0;
      root <= '0;
      cnt  <= 5'd31;
    end else if (busy) begin
      dsh  <= {dsh[59:0], 2'b00};
      rem  <= ge ? diff[32:0] : rem_sh[32:0];
      root <= {root[29:0], ge};
      cnt  <= cnt - 5'd1;
    end
  end

  assign rsp.done = done;
  assign rsp.root = root;

endmodule
